// File: design/sbt_pkg.sv
package sbt_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] edge_val;
  } pair_t;

  // What a cell shows its right-hand neighbor
  typedef struct packed {
    logic  valid;
    logic  le;      // valid and edge <= key
    pair_t pair;
  } link_t;

endpackage

// File: design/sbt_cell.sv
module sbt_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  ins_en,
  input  logic                                  cap_en,
  input  logic signed [sbt_pkg::DATA_W-1:0]     key,
  input  logic signed [sbt_pkg::DATA_W-1:0]     value,
  input  sbt_pkg::link_t                        prev_i,
  input  logic                                  next_le_i,
  output sbt_pkg::link_t                        self_o,
  output sbt_pkg::pair_t                        hit_o
);

  logic                           valid_r;
  logic signed [sbt_pkg::DATA_W-1:0] edge_r;
  logic signed [sbt_pkg::DATA_W-1:0] value_r;
  sbt_pkg::pair_t                 hit_r;
  logic                           le;
  logic                           take_prev;
  logic                           take_new;
  logic                           hit;

  assign le        = valid_r && (edge_r <= key);
  assign take_prev = prev_i.valid && !prev_i.le;
  assign take_new  = prev_i.le && !le;
  // last entry with edge <= key
  assign hit       = le && !next_le_i;

  assign self_o.valid         = valid_r;
  assign self_o.le            = le;
  assign self_o.pair.value    = value_r;
  assign self_o.pair.edge_val = edge_r;
  assign hit_o                = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ins_en && (take_prev || take_new)) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (take_prev) begin
        edge_r  <= prev_i.pair.edge_val;
        value_r <= prev_i.pair.value;
      end else if (take_new) begin
        edge_r  <= key;
        value_r <= value;
      end
    end
    if (cap_en) begin
      hit_r.value    <= hit ? value_r : '0;
      hit_r.edge_val <= hit ? edge_r : '0;
    end
  end

endmodule

// File: design/sbt_reduce.sv
module sbt_reduce #(
  parameter int unsigned DEPTH = 64
) (
  input  sbt_pkg::pair_t hits_i [DEPTH],
  output sbt_pkg::pair_t pair_o
);

  // at most one cell holds a nonzero hit
  always_comb begin
    pair_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pair_o = pair_o | hits_i[i];
    end
  end

endmodule

// File: design/sorted_bin_table_lookup_top.sv
// Flow: the item is registered; compare/shift in the cell row, then
// an OR reduce of the one-hot hit registers into the output register.
// in_stall stays high until the previous item reaches the output register.
// Reset (rst_n low, synchronous) empties the table and drops out_valid.
module sorted_bin_table_lookup_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic signed [31:0]                in_key,
  input  logic signed [31:0]                in_entry_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_bin_value,
  output logic signed [31:0]                out_bin_base,
  output logic [1:0]                        out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL
  } state_t;

  state_t                               state_r;
  logic                                 cmd_r;
  logic signed [sbt_pkg::DATA_W-1:0]    key_r;
  logic signed [sbt_pkg::DATA_W-1:0]    val_r;
  sbt_pkg::status_t                     status_r;
  logic                                 out_valid_r;
  logic signed [sbt_pkg::DATA_W-1:0]    out_value_r;
  logic signed [sbt_pkg::DATA_W-1:0]    out_base_r;
  logic [1:0]                           out_status_r;

  sbt_pkg::link_t  links [DEPTH+1];
  logic            le_vec [DEPTH+1];
  sbt_pkg::pair_t  hits [DEPTH];
  sbt_pkg::pair_t  sel_pair;
  logic            full;
  logic            ins_en;
  logic            cap_en;
  logic            accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign full     = links[DEPTH].valid;
  assign ins_en   = (state_r == S_CMP) && (cmd_r == sbt_pkg::CMD_INSERT) && !full;
  assign cap_en   = (state_r == S_CMP) && (cmd_r == sbt_pkg::CMD_LOOKUP);

  // virtual left neighbor: lets cell 0 take the new pair when cell 0 is empty or its edge is above the key
  assign links[0].valid = 1'b1;
  assign links[0].le    = 1'b1;
  assign links[0].pair  = '0;
  assign le_vec[DEPTH]  = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign le_vec[g] = links[g+1].le;
    sbt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ins_en    (ins_en),
      .cap_en    (cap_en),
      .key       (key_r),
      .value     (val_r),
      .prev_i    (links[g]),
      .next_le_i (le_vec[g+1]),
      .self_o    (links[g+1]),
      .hit_o     (hits[g])
    );
  end

  sbt_reduce #(.DEPTH(DEPTH)) u_reduce (
    .hits_i (hits),
    .pair_o (sel_pair)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_SEL) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_SEL;
        end
        S_SEL: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      key_r <= in_key;
      val_r <= in_entry_value;
    end
    if (state_r == S_CMP) begin
      if (cmd_r == sbt_pkg::CMD_INSERT) begin
        status_r <= full ? sbt_pkg::ST_FULL : sbt_pkg::ST_OK;
      end else if (!links[1].valid) begin
        status_r <= sbt_pkg::ST_EMPTY;
      end else if (!links[1].le) begin
        status_r <= sbt_pkg::ST_BELOW;
      end else begin
        status_r <= sbt_pkg::ST_OK;
      end
    end
    if ((state_r == S_SEL) && (!out_valid_r || !out_stall)) begin
      // hit registers are not captured on insert
      out_value_r  <= (cmd_r == sbt_pkg::CMD_LOOKUP) ? sel_pair.value : '0;
      out_base_r   <= (cmd_r == sbt_pkg::CMD_LOOKUP) ? sel_pair.edge_val : '0;
      out_status_r <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_value = out_value_r;
  assign out_bin_base  = out_base_r;
  assign out_status    = out_status_r;

endmodule
